// ===== hw/rtl/bgd_pkg.sv =====
// Package for the button gesture detector: field widths, register map
// and configuration reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

  localparam int unsigned TimeW    = 63;
  localparam int unsigned ThrW     = 32;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [ThrW-1:0] LongPressRst   = ThrW'(1000000);
  localparam logic [ThrW-1:0] DoublePressRst = ThrW'(300000);

  // Register index, taken from paddr bit 2 (word-aligned map)
  typedef enum logic {
    REG_LONG_PRESS   = 1'b0,
    REG_DOUBLE_PRESS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic press_event;
    logic double_press_event;
    logic short_press_event;
    logic long_press_event;
    logic release_event;
  } events_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgd_in_if.sv =====
// Input channel of the button gesture detector: one switch poll per transfer.
// Depends on bgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bgd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      pin_level;
  logic [bgd_pkg::TimeW-1:0] now_us;

  modport source (output valid, output pin_level, output now_us, input ready);
  modport sink   (input valid, input pin_level, input now_us, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bgd_out_if.sv =====
// Result channel of the button gesture detector: five event flags per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bgd_out_if;
  logic valid;
  logic ready;
  logic press_event;
  logic double_press_event;
  logic short_press_event;
  logic long_press_event;
  logic release_event;

  modport source (output valid, output press_event, output double_press_event,
                  output short_press_event, output long_press_event,
                  output release_event, input ready);
  modport sink   (input valid, input press_event, input double_press_event,
                  input short_press_event, input long_press_event,
                  input release_event, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/button_gesture_detector.sv =====
// Button gesture detector top level: poll register, event logic, result register.
// Depends on bgd_pkg, bgd_in_if and bgd_out_if.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   in_s     | sink      | pin_level, now_us
//   out_s    | source    | press/double/short/long/release event flags
//   apb      | slave     | long_press_us (0x0), double_press_us (0x4)
//
// One poll per cycle while out_s is not stalled; a poll passes through the poll
// register, then the result register, before it shows on out_s.
// The event logic is three 64-bit subtracts and four 63-bit compares against the
// two thresholds and the gesture state.
// Reset clears the gesture state and loads the default thresholds.
// A stalled out_s holds the result; in_s keeps taking a poll while the poll
// register is empty or moves on to a result register that is free or being
// drained in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module button_gesture_detector (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  bgd_in_if.sink                            in_s,
  bgd_out_if.source                         out_s,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [bgd_pkg::ApbAddrW-1:0]      paddr,
  input  wire  [bgd_pkg::ApbDataW-1:0]      pwdata,
  output logic [bgd_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready
);
  import bgd_pkg::*;

  // configuration
  logic [ThrW-1:0] long_us_q, double_us_q;
  reg_idx_e        reg_idx;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_us_q   <= LongPressRst;
      double_us_q <= DoublePressRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LONG_PRESS:   long_us_q   <= pwdata[ThrW-1:0];
        REG_DOUBLE_PRESS: double_us_q <= pwdata[ThrW-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LONG_PRESS:   prdata = ApbDataW'(long_us_q);
      REG_DOUBLE_PRESS: prdata = ApbDataW'(double_us_q);
      default:          prdata = '0;
    endcase
  end

  // poll register and flow control
  logic             s1_valid_q, s1_pin_q;
  logic [TimeW-1:0] s1_now_q;
  logic             out_valid_q;
  logic             s1_adv;
  events_t          ev_d, ev_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_s.ready);
  assign in_s.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.valid && in_s.ready) begin
      s1_pin_q <= in_s.pin_level;
      s1_now_q <= in_s.now_us;
    end
  end

  // gesture state
  logic             was_pressed_q, was_pressed_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic [TimeW-1:0] win_start_q, win_start_d;
  logic             armed_q, armed_d;
  logic             long_rep_q, long_rep_d;

  logic             pressed, edge_press, edge_release;
  logic [TimeW-1:0] long_start;
  logic [TimeW:0]   d_win, d_rel, d_long;
  logic             win_below, rel_below_long, rel_above_dbl, long_below;

  assign pressed      = !s1_pin_q;
  assign edge_press   = pressed && !was_pressed_q;
  assign edge_release = !pressed && was_pressed_q;
  // a press edge restarts the hold time on this very poll
  assign long_start   = edge_press ? s1_now_q : press_start_q;

  // borrow bit set means time went backwards: counts as below every threshold
  assign d_win  = {1'b0, s1_now_q} - {1'b0, win_start_q};
  assign d_rel  = {1'b0, s1_now_q} - {1'b0, press_start_q};
  assign d_long = {1'b0, s1_now_q} - {1'b0, long_start};

  assign win_below      = d_win[TimeW] || (d_win[TimeW-1:0] < TimeW'(double_us_q));
  assign rel_below_long = d_rel[TimeW] || (d_rel[TimeW-1:0] < TimeW'(long_us_q));
  assign rel_above_dbl  = !d_rel[TimeW] && (d_rel[TimeW-1:0] > TimeW'(double_us_q));
  assign long_below     = d_long[TimeW] || (d_long[TimeW-1:0] < TimeW'(long_us_q));

  always_comb begin
    ev_d          = '0;
    was_pressed_d = pressed;
    press_start_d = press_start_q;
    win_start_d   = win_start_q;
    armed_d       = armed_q;
    long_rep_d    = long_rep_q;

    if (edge_press) begin
      ev_d.press_event = 1'b1;
      press_start_d    = s1_now_q;
      if (armed_q && win_below) begin
        ev_d.double_press_event = 1'b1;
        armed_d                 = 1'b0;
      end else begin
        win_start_d = s1_now_q;
        armed_d     = 1'b1;
      end
    end

    if (edge_release) begin
      ev_d.release_event     = 1'b1;
      ev_d.short_press_event = rel_below_long && rel_above_dbl;
    end

    if (pressed) begin
      if (!long_rep_q && !long_below) begin
        ev_d.long_press_event = 1'b1;
        long_rep_d            = 1'b1;
      end
    end else begin
      long_rep_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q <= 1'b0;
      press_start_q <= '0;
      win_start_q   <= '0;
      armed_q       <= 1'b0;
      long_rep_q    <= 1'b0;
    end else if (s1_adv) begin
      was_pressed_q <= was_pressed_d;
      press_start_q <= press_start_d;
      win_start_q   <= win_start_d;
      armed_q       <= armed_d;
      long_rep_q    <= long_rep_d;
    end
  end

  // result register: hold while the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      ev_q <= ev_d;
    end
  end

  assign out_s.valid              = out_valid_q;
  assign out_s.press_event        = ev_q.press_event;
  assign out_s.double_press_event = ev_q.double_press_event;
  assign out_s.short_press_event  = ev_q.short_press_event;
  assign out_s.long_press_event   = ev_q.long_press_event;
  assign out_s.release_event      = ev_q.release_event;

endmodule

`default_nettype wire

// ===== hw/rtl/bgd_checker.sv =====
// Port-level checks for the button gesture detector, bound to the top level.
// Depends on button_gesture_detector.
`timescale 1ns / 1ps
`default_nettype none

module bgd_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire press_i,
  input wire double_i,
  input wire short_i,
  input wire long_i,
  input wire release_i
);

  // a double press is always a press edge
  a_double_is_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && double_i |-> press_i)
    else $error("double press without press edge");

  // a short press is always reported with its release
  a_short_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && short_i |-> release_i)
    else $error("short press without release edge");

  // one sample cannot both press and release
  a_press_xor_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(press_i && release_i))
    else $error("press and release in one poll");

  // a long press needs the switch held, so never with a release
  a_long_not_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(long_i && release_i))
    else $error("long press together with release");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({press_i, double_i, short_i, long_i, release_i}))
    else $error("result changed while stalled");

endmodule

bind button_gesture_detector bgd_checker u_bgd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_s.valid),
  .out_ready_i (out_s.ready),
  .press_i     (out_s.press_event),
  .double_i    (out_s.double_press_event),
  .short_i     (out_s.short_press_event),
  .long_i      (out_s.long_press_event),
  .release_i   (out_s.release_event)
);

`default_nettype wire
